FILE: sv/qsst_pkg.sv
package qsst_pkg;

  // Fixed channel count and field widths of the tracker
  localparam int CHANNELS  = 4;
  localparam int CH_W      = 2;
  localparam int AVG_OUT_W = 10;
  localparam int DIFF_W    = 11;
  localparam int CFG_W     = 8;

  // Result queue sizing
  localparam int OUT_DEPTH = 4;
  localparam int PTR_W     = 2;
  localparam int CNT_W     = 3;

  localparam logic [CFG_W-1:0] DEADBAND_RESET = 8'd10;

  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_POS    = 2'd1,
    CMD_NEG    = 2'd2,
    CMD_LOCKED = 2'd3
  } cmd_e;

  typedef enum logic {
    ACT_SAMPLE = 1'b0,
    ACT_DECIDE = 1'b1
  } act_e;

  typedef struct packed {
    logic [CH_W-1:0]          channel;
    logic [AVG_OUT_W-1:0]     average;
    logic signed [DIFF_W-1:0] x_diff;
    logic signed [DIFF_W-1:0] y_diff;
    cmd_e                     x_cmd;
    cmd_e                     y_cmd;
  } result_t;

endpackage

FILE: sv/qsst_ram.sv
module qsst_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 20,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/qsst_out_fifo.sv
module qsst_out_fifo (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  qsst_pkg::result_t          push_data_i,
  input  logic                       pop_i,
  output qsst_pkg::result_t          pop_data_o,
  output logic                       valid_o,
  output logic [qsst_pkg::CNT_W-1:0] count_o
);

  qsst_pkg::result_t               buf_q [qsst_pkg::OUT_DEPTH];
  logic [qsst_pkg::PTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [qsst_pkg::PTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [qsst_pkg::CNT_W-1:0]      count_q, count_d;
  logic                            pop_ok;

  assign pop_ok = pop_i && (count_q != '0);

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_ok})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed beat
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o = buf_q[rd_ptr_q];
  assign valid_o    = (count_q != '0);
  assign count_o    = count_q;

endmodule

FILE: sv/quad_sensor_sun_tracker.sv
// Four-quadrant sun tracker with a moving average per light sensor.
// Input channel (in_valid_i / in_ready_o): action_i = 0 is a sample beat for the
// round-robin channel 0,1,2,3,0,...; action_i = 1 is a decide beat that turns the
// channel averages and the four end switches into one command per axis.
// Output channel (out_valid_o / out_ready_i): exactly one result beat per input
// beat, in order. Configuration: cfg_we_i writes cfg_data_i into the deadband.
// Pipeline: stage 1 does the history and running-sum read-modify-write, stage 2
// divides by TAPS and decides; then the result queue presents it on out_valid_o.
// Throughput: one beat per cycle while in_ready_o is high. Each channel's history and
// running sum live in single-port-read RAMs; a channel is revisited only every fourth
// sample, so the read-modify-write never overlaps itself.
// Stall: a four-entry result queue holds finished beats; in_ready_o drops when the
// queue plus the two pipeline stages hold four beats, and nothing is lost.
// Reset: histories, averages and the channel pointer read as zero at once (valid
// bits per entry, no clearing pass); deadband returns to 10.
module quad_sensor_sun_tracker #(
  parameter int TAPS        = 5,
  parameter int SAMPLE_BITS = 10
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [qsst_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                action_i,
  input  logic [9:0]                          sample_i,
  input  logic                                limit_x_right_i,
  input  logic                                limit_x_left_i,
  input  logic                                limit_y_up_i,
  input  logic                                limit_y_down_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [qsst_pkg::CH_W-1:0]           channel_o,
  output logic [qsst_pkg::AVG_OUT_W-1:0]      channel_average_o,
  output logic signed [qsst_pkg::DIFF_W-1:0]  x_difference_o,
  output logic signed [qsst_pkg::DIFF_W-1:0]  y_difference_o,
  output logic [1:0]                          x_command_o,
  output logic [1:0]                          y_command_o
);

  localparam int HIST_DEPTH = qsst_pkg::CHANNELS * TAPS;
  localparam int HADDR_W    = $clog2(HIST_DEPTH);
  localparam int TAP_W      = $clog2(TAPS);
  localparam int SUM_W      = SAMPLE_BITS + $clog2(TAPS);
  // Reciprocal of TAPS, exact for every sum below 2^SUM_W
  localparam int K          = SUM_W + $clog2(TAPS);
  localparam int PROD_W     = SUM_W + K + 1;
  localparam logic [K:0] RECIP = (K + 1)'(((64'd1 << K) / TAPS) + 64'd1);
  localparam int DW = (SAMPLE_BITS + 1 > qsst_pkg::DIFF_W) ? SAMPLE_BITS + 1
                                                           : qsst_pkg::DIFF_W;

  function automatic qsst_pkg::cmd_e axis_decide(
    input logic signed [DW-1:0] d,
    input logic [qsst_pkg::CFG_W-1:0] db,
    input logic pos_lim,
    input logic neg_lim
  );
    logic signed [DW-1:0] dbs;
    qsst_pkg::cmd_e cmd;
    dbs = $signed(DW'(db));
    if (d > dbs) begin
      cmd = pos_lim ? qsst_pkg::CMD_NONE : qsst_pkg::CMD_POS;
    end else if (d < -dbs) begin
      cmd = neg_lim ? qsst_pkg::CMD_NONE : qsst_pkg::CMD_NEG;
    end else begin
      cmd = qsst_pkg::CMD_LOCKED;
    end
    return cmd;
  endfunction

  // ---------------------------------------------------------------- accept
  logic                              in_accept;
  logic                              in_sample;
  logic [31:0]                       sample_wide;
  logic [qsst_pkg::CNT_W-1:0]        fifo_count;
  logic [qsst_pkg::CNT_W-1:0]        inflight;
  logic [qsst_pkg::CFG_W-1:0]        deadband_q;
  logic [qsst_pkg::CH_W-1:0]         next_ch_q;
  logic [TAP_W-1:0]                  wp_q [qsst_pkg::CHANNELS];
  logic [HADDR_W-1:0]                hist_raddr;
  logic [HIST_DEPTH-1:0]             hist_valid_q;
  logic [qsst_pkg::CHANNELS-1:0]     sum_valid_q;

  logic                              s1_valid_q;
  qsst_pkg::act_e                    s1_action_q;
  logic [qsst_pkg::CH_W-1:0]         s1_ch_q;
  logic [SAMPLE_BITS-1:0]            s1_sample_q;
  logic [HADDR_W-1:0]                s1_addr_q;
  logic                              s1_hvalid_q;
  logic                              s1_svalid_q;
  logic [3:0]                        s1_limits_q;

  logic                              s2_valid_q;
  qsst_pkg::act_e                    s2_action_q;
  logic [qsst_pkg::CH_W-1:0]         s2_ch_q;
  logic [SUM_W-1:0]                  s2_sum_q;
  logic [3:0]                        s2_limits_q;

  assign inflight   = fifo_count + qsst_pkg::CNT_W'(s1_valid_q)
                                 + qsst_pkg::CNT_W'(s2_valid_q);
  assign in_ready_o = (inflight < qsst_pkg::CNT_W'(qsst_pkg::OUT_DEPTH));
  assign in_accept  = in_valid_i && in_ready_o;
  assign in_sample  = in_accept && (qsst_pkg::act_e'(action_i) == qsst_pkg::ACT_SAMPLE);
  assign sample_wide = 32'(sample_i);
  assign hist_raddr = HADDR_W'(32'(next_ch_q) * TAPS + 32'(wp_q[next_ch_q]));

  // Hold the deadband register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadband_q <= qsst_pkg::DEADBAND_RESET;
    end else if (cfg_we_i) begin
      deadband_q <= cfg_data_i;
    end
  end

  // Advance the channel pointer and the per-channel history pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_ch_q <= '0;
      for (int c = 0; c < qsst_pkg::CHANNELS; c++) begin
        wp_q[c] <= '0;
      end
    end else if (in_sample) begin
      next_ch_q <= next_ch_q + 1'b1;
      if (wp_q[next_ch_q] == TAP_W'(TAPS - 1)) begin
        wp_q[next_ch_q] <= '0;
      end else begin
        wp_q[next_ch_q] <= wp_q[next_ch_q] + 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- stage 1
  logic [SAMPLE_BITS-1:0] hist_rdata;
  logic [SUM_W-1:0]       sum_rdata;
  logic [SAMPLE_BITS-1:0] oldest;
  logic [SUM_W-1:0]       old_sum;
  logic [SUM_W-1:0]       new_sum;
  logic                   s1_write;

  qsst_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (HIST_DEPTH)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (s1_write),
    .waddr_i (s1_addr_q),
    .wdata_i (s1_sample_q),
    .re_i    (in_sample),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

  qsst_ram #(
    .WIDTH (SUM_W),
    .DEPTH (qsst_pkg::CHANNELS)
  ) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (s1_write),
    .waddr_i (s1_ch_q),
    .wdata_i (new_sum),
    .re_i    (in_sample),
    .raddr_i (next_ch_q),
    .rdata_o (sum_rdata)
  );

  // Drop the oldest tap from the running sum, add the new one
  assign s1_write = s1_valid_q && (s1_action_q == qsst_pkg::ACT_SAMPLE);
  assign oldest   = s1_hvalid_q ? hist_rdata : '0;
  assign old_sum  = s1_svalid_q ? sum_rdata : '0;
  assign new_sum  = old_sum - SUM_W'(oldest) + SUM_W'(s1_sample_q);

  // Mark written entries; unwritten ones read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_valid_q <= '0;
      sum_valid_q  <= '0;
    end else if (s1_write) begin
      hist_valid_q[s1_addr_q] <= 1'b1;
      sum_valid_q[s1_ch_q]    <= 1'b1;
    end
  end

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_accept;
      s2_valid_q <= s1_valid_q;
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_action_q <= qsst_pkg::act_e'(action_i);
      s1_ch_q     <= next_ch_q;
      s1_sample_q <= sample_wide[SAMPLE_BITS-1:0];
      s1_addr_q   <= hist_raddr;
      s1_hvalid_q <= hist_valid_q[hist_raddr];
      s1_svalid_q <= sum_valid_q[next_ch_q];
      s1_limits_q <= {limit_y_down_i, limit_y_up_i, limit_x_left_i, limit_x_right_i};
    end
    if (s1_valid_q) begin
      s2_action_q <= s1_action_q;
      s2_ch_q     <= s1_ch_q;
      s2_sum_q    <= new_sum;
      s2_limits_q <= s1_limits_q;
    end
  end

  // ---------------------------------------------------------------- stage 2
  logic [PROD_W-1:0]      prod;
  logic [SAMPLE_BITS-1:0] quot;
  logic [31:0]            quot_wide;
  logic [SAMPLE_BITS-1:0] avg_q    [qsst_pkg::CHANNELS];
  logic [SAMPLE_BITS-1:0] avg_next [qsst_pkg::CHANNELS];
  logic                   s2_sample;
  logic signed [DW-1:0]   dx, dy;
  qsst_pkg::result_t      res;

  // Divide the running sum by TAPS through the reciprocal
  assign prod      = PROD_W'(s2_sum_q) * PROD_W'(RECIP);
  assign quot      = prod[K +: SAMPLE_BITS];
  assign quot_wide = 32'(quot);
  assign s2_sample = s2_valid_q && (s2_action_q == qsst_pkg::ACT_SAMPLE);

  // Update the averages and form the result beat
  always_comb begin
    for (int c = 0; c < qsst_pkg::CHANNELS; c++) begin
      avg_next[c] = avg_q[c];
    end
    if (s2_sample) begin
      avg_next[s2_ch_q] = quot;
    end
    dx = $signed(DW'(avg_next[0])) - $signed(DW'(avg_next[1]));
    dy = $signed(DW'(avg_next[2])) - $signed(DW'(avg_next[3]));
    res.x_diff = dx[qsst_pkg::DIFF_W-1:0];
    res.y_diff = dy[qsst_pkg::DIFF_W-1:0];
    if (s2_action_q == qsst_pkg::ACT_SAMPLE) begin
      res.channel = s2_ch_q;
      res.average = quot_wide[qsst_pkg::AVG_OUT_W-1:0];
      res.x_cmd   = qsst_pkg::CMD_NONE;
      res.y_cmd   = qsst_pkg::CMD_NONE;
    end else begin
      res.channel = '0;
      res.average = '0;
      res.x_cmd   = axis_decide(dx, deadband_q, s2_limits_q[0], s2_limits_q[1]);
      res.y_cmd   = axis_decide(dy, deadband_q, s2_limits_q[3], s2_limits_q[2]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < qsst_pkg::CHANNELS; c++) begin
        avg_q[c] <= '0;
      end
    end else begin
      for (int c = 0; c < qsst_pkg::CHANNELS; c++) begin
        avg_q[c] <= avg_next[c];
      end
    end
  end

  // ---------------------------------------------------------------- output
  qsst_pkg::result_t out_res;

  qsst_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s2_valid_q),
    .push_data_i (res),
    .pop_i       (out_ready_i),
    .pop_data_o  (out_res),
    .valid_o     (out_valid_o),
    .count_o     (fifo_count)
  );

  assign channel_o         = out_res.channel;
  assign channel_average_o = out_res.average;
  assign x_difference_o    = out_res.x_diff;
  assign y_difference_o    = out_res.y_diff;
  assign x_command_o       = out_res.x_cmd;
  assign y_command_o       = out_res.y_cmd;

  // ---------------------------------------------------------------- checks
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight <= qsst_pkg::CNT_W'(qsst_pkg::OUT_DEPTH))
    else $error("result queue and pipeline hold more beats than the queue depth");

  a_no_rmw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_sample && s1_write) |-> (hist_raddr != s1_addr_q))
    else $error("history read hits the entry being written back");

  a_push_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |=> out_valid_o)
    else $error("pushed result beat not presented");

endmodule
